[hdl/six_step_commutation_gate_driver_top_macros.svh]
// ----------------------------------------------------------------------------
// six step commutation gate driver assertion macros
// overlapping-implication and next-cycle implication checks, removable by
// defining ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef SIX_STEP_COMMUTATION_GATE_DRIVER_TOP_MACROS_SVH
`define SIX_STEP_COMMUTATION_GATE_DRIVER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// consequent must hold in the same cycle as the antecedent
`define SSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssc assertion failed");
// consequent must hold in the cycle after the antecedent
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssc assertion failed");
`else
`define SSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/ssc_pkg.sv]
// ----------------------------------------------------------------------------
// ssc_pkg
// shared types, codes and lookup functions of the six-step commutation driver
// ----------------------------------------------------------------------------
package ssc_pkg;

    // widths
    localparam int COMPARE_BITS   = 16;
    localparam int PERIOD_BITS    = 16;
    localparam int DUTY_BITS      = 16;
    localparam int DUTY_FRAC_BITS = 15;
    localparam int NUM_GATES      = 6;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [COMPARE_BITS-1:0] CMP_FULL     = {COMPARE_BITS{1'b1}};
    localparam logic [PERIOD_BITS-1:0]  PERIOD_RESET = {PERIOD_BITS{1'b1}};
    localparam logic [DUTY_BITS-1:0]    DUTY_ONE     = DUTY_BITS'(1) << DUTY_FRAC_BITS;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PWM_PERIOD = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COMM_MODE  = 1'd1;

    // commands
    localparam logic [2:0] CMD_ARM      = 3'd0;
    localparam logic [2:0] CMD_OFF      = 3'd1;
    localparam logic [2:0] CMD_ADVANCE  = 3'd2;
    localparam logic [2:0] CMD_SET_STEP = 3'd3;
    localparam logic [2:0] CMD_SET_DUTY = 3'd4;

    // steps
    localparam logic [2:0] STEP_AB = 3'd0;
    localparam logic [2:0] STEP_AC = 3'd1;
    localparam logic [2:0] STEP_BA = 3'd2;
    localparam logic [2:0] STEP_BC = 3'd3;
    localparam logic [2:0] STEP_CA = 3'd4;
    localparam logic [2:0] STEP_CB = 3'd5;

    // commutation modes
    localparam logic [2:0] MODE_LOWON_PWMHIGH  = 3'd0;
    localparam logic [2:0] MODE_LOWON_PWMLOW   = 3'd1;
    localparam logic [2:0] MODE_LOWON_PWMBOTH  = 3'd2;
    localparam logic [2:0] MODE_HIGHON_PWMLOW  = 3'd3;
    localparam logic [2:0] MODE_HIGHON_PWMHIGH = 3'd4;
    localparam logic [2:0] MODE_HIGHON_PWMBOTH = 3'd5;

    // phases
    localparam logic [1:0] PHASE_A = 2'd0;
    localparam logic [1:0] PHASE_B = 2'd1;
    localparam logic [1:0] PHASE_C = 2'd2;

    // gate roles
    localparam logic [1:0] ROLE_OFF = 2'd0;
    localparam logic [1:0] ROLE_ON  = 2'd1;
    localparam logic [1:0] ROLE_PWM = 2'd2;

    // role slots within a mode
    localparam logic [1:0] SLOT_FIRST_LOW   = 2'd0;
    localparam logic [1:0] SLOT_FIRST_HIGH  = 2'd1;
    localparam logic [1:0] SLOT_SECOND_LOW  = 2'd2;
    localparam logic [1:0] SLOT_SECOND_HIGH = 2'd3;

    // gate order: a_low, a_high, b_low, b_high, c_low, c_high
    localparam int GATE_A_LOW  = 0;
    localparam int GATE_A_HIGH = 1;
    localparam int GATE_B_LOW  = 2;
    localparam int GATE_B_HIGH = 3;
    localparam int GATE_C_LOW  = 4;
    localparam int GATE_C_HIGH = 5;

    typedef logic [NUM_GATES-1:0][COMPARE_BITS-1:0] gates_t;

    typedef struct packed {
        logic [2:0]           command;
        logic [2:0]           step_value;
        logic [DUTY_BITS-1:0] duty_fraction;
    } cmd_t;

    typedef struct packed {
        gates_t     gates;
        logic [2:0] step;
        logic       armed;
        logic       fault;
    } res_t;

    // control from the pipeline to the state block
    typedef struct packed {
        logic fire;
        cmd_t item;
    } ctl_t;

    // advance order AB>CB>CA>BA>BC>AC>AB, bad steps count as AB
    function automatic logic [2:0] step_advance(input logic [2:0] s);
        logic [2:0] n;
        unique case (s)
            STEP_AC: n = STEP_AB;
            STEP_BA: n = STEP_BC;
            STEP_BC: n = STEP_AC;
            STEP_CA: n = STEP_BA;
            STEP_CB: n = STEP_CA;
            default: n = STEP_CB;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] step_first_phase(input logic [2:0] s);
        logic [1:0] p;
        unique case (s) inside
            STEP_AB, STEP_AC: p = PHASE_A;
            STEP_BA, STEP_BC: p = PHASE_B;
            default:          p = PHASE_C;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] step_second_phase(input logic [2:0] s);
        logic [1:0] p;
        unique case (s) inside
            STEP_BA, STEP_CA: p = PHASE_A;
            STEP_AB, STEP_CB: p = PHASE_B;
            default:          p = PHASE_C;
        endcase
        return p;
    endfunction

    // low-on modes drive the first low gate on, high-on modes the first high gate
    function automatic logic [1:0] mode_role(input logic [2:0] mode, input logic [1:0] slot);
        logic       low_on;
        logic       pwm_low;
        logic       pwm_high;
        logic [1:0] r;
        low_on   = (mode == MODE_LOWON_PWMHIGH) || (mode == MODE_LOWON_PWMLOW)
                || (mode == MODE_LOWON_PWMBOTH);
        pwm_low  = (mode == MODE_LOWON_PWMLOW) || (mode == MODE_LOWON_PWMBOTH)
                || (mode == MODE_HIGHON_PWMLOW) || (mode == MODE_HIGHON_PWMBOTH);
        pwm_high = (mode == MODE_LOWON_PWMHIGH) || (mode == MODE_LOWON_PWMBOTH)
                || (mode == MODE_HIGHON_PWMHIGH) || (mode == MODE_HIGHON_PWMBOTH);
        unique case (slot)
            SLOT_FIRST_LOW:  r = low_on ? ROLE_ON : ROLE_OFF;
            SLOT_FIRST_HIGH: r = low_on ? ROLE_OFF : ROLE_ON;
            SLOT_SECOND_LOW: r = pwm_low ? ROLE_PWM : ROLE_OFF;
            default:         r = pwm_high ? ROLE_PWM : ROLE_OFF;
        endcase
        return r;
    endfunction

endpackage

[hdl/ssc_channels.sv]
// ----------------------------------------------------------------------------
// ssc channels
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface ssc_cmd_if
    import ssc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [2:0]           command;
    logic [2:0]           step_value;
    logic [DUTY_BITS-1:0] duty_fraction;

    modport source (output valid, command, step_value, duty_fraction, input ready);
    modport sink (input valid, command, step_value, duty_fraction, output ready);
endinterface

interface ssc_res_if
    import ssc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [COMPARE_BITS-1:0] compare_a_low;
    logic [COMPARE_BITS-1:0] compare_a_high;
    logic [COMPARE_BITS-1:0] compare_b_low;
    logic [COMPARE_BITS-1:0] compare_b_high;
    logic [COMPARE_BITS-1:0] compare_c_low;
    logic [COMPARE_BITS-1:0] compare_c_high;
    logic [2:0]              current_step;
    logic                    is_armed;
    logic                    fault;

    modport source (output valid, compare_a_low, compare_a_high, compare_b_low,
                    compare_b_high, compare_c_low, compare_c_high, current_step,
                    is_armed, fault, input ready);
    modport sink (input valid, compare_a_low, compare_a_high, compare_b_low,
                  compare_b_high, compare_c_low, compare_c_high, current_step,
                  is_armed, fault, output ready);
endinterface

[hdl/ssc_gate_map.sv]
// ----------------------------------------------------------------------------
// ssc_gate_map
// maps the mode's gate roles onto the two active phases of a step and turns
// each role into a compare value
// ----------------------------------------------------------------------------
module ssc_gate_map
    import ssc_pkg::*;
(
    input  logic [2:0]              step,
    input  logic [2:0]              mode,
    input  logic                    armed,
    input  logic [COMPARE_BITS-1:0] duty,
    output gates_t                  gates
);

    logic [1:0] p1;
    logic [1:0] p2;

    assign p1 = step_first_phase(step);
    assign p2 = step_second_phase(step);

    // per gate: pick the role slot, then the compare value
    always_comb
    begin
        logic [1:0] role;
        logic [1:0] phase;
        logic       high;
        for (int g = 0; g < NUM_GATES; g++)
        begin
            phase = 2'(g / 2);
            high  = 1'(g % 2);
            role  = ROLE_OFF;
            if (phase == p1)
                role = mode_role(mode, high ? SLOT_FIRST_HIGH : SLOT_FIRST_LOW);
            else if (phase == p2)
                role = mode_role(mode, high ? SLOT_SECOND_HIGH : SLOT_SECOND_LOW);
            case (role)
                ROLE_ON:  gates[g] = armed ? CMP_FULL : '0;
                ROLE_PWM: gates[g] = armed ? duty : '0;
                default:  gates[g] = '0;
            endcase
        end
    end

endmodule

[hdl/ssc_state.sv]
// ----------------------------------------------------------------------------
// ssc_state
// driver state and configuration registers with the per-item update logic
// ----------------------------------------------------------------------------
`include "six_step_commutation_gate_driver_top_macros.svh"

module ssc_state
    import ssc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  ctl_t                      ctl,
    output res_t                      result
);

    logic [PERIOD_BITS-1:0]  period_reg;
    logic [2:0]              mode_reg;
    logic [2:0]              step_reg;
    logic [2:0]              step_next;
    logic                    armed_reg;
    logic                    armed_next;
    logic [COMPARE_BITS-1:0] duty_reg;
    logic [COMPARE_BITS-1:0] duty_next;
    gates_t                  gate_reg;
    gates_t                  gate_next;
    logic                    fault;

    logic [2:0]                                     target_step;
    gates_t                                         mapped_gates;
    logic                                           mode_bad;
    logic [PERIOD_BITS+DUTY_BITS-1:0]               duty_product;
    logic [PERIOD_BITS+DUTY_BITS-DUTY_FRAC_BITS-1:0] duty_scaled;
    logic [COMPARE_BITS-1:0]                        duty_sat;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            mode_reg   <= MODE_LOWON_PWMHIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PWM_PERIOD: period_reg <= cfg_data[PERIOD_BITS-1:0];
                default:        mode_reg   <= cfg_data[2:0];
            endcase
        end
    end

    // step the item targets and the gates it would drive
    assign target_step = (ctl.item.command == CMD_ADVANCE) ? step_advance(step_reg)
                                                           : ctl.item.step_value;
    assign mode_bad    = mode_reg > MODE_HIGHON_PWMBOTH;

    ssc_gate_map u_gate_map (
        .step  (target_step),
        .mode  (mode_reg),
        .armed (armed_reg),
        .duty  (duty_reg),
        .gates (mapped_gates)
    );

    // period times duty, Q1.15 scaled back down and clamped to the full value
    assign duty_product = period_reg * ctl.item.duty_fraction;
    assign duty_scaled  = duty_product[PERIOD_BITS+DUTY_BITS-1:DUTY_FRAC_BITS];
    assign duty_sat     = (64'(duty_scaled) > 64'(CMP_FULL)) ? CMP_FULL
                                                             : COMPARE_BITS'(duty_scaled);

    // command decode
    always_comb
    begin
        step_next  = step_reg;
        armed_next = armed_reg;
        duty_next  = duty_reg;
        gate_next  = gate_reg;
        fault      = 1'b0;
        unique case (ctl.item.command) inside
            CMD_ARM:
            begin
                armed_next = 1'b1;
            end
            CMD_OFF:
            begin
                armed_next = 1'b0;
                duty_next  = '0;
                gate_next  = '0;
            end
            CMD_ADVANCE, CMD_SET_STEP:
            begin
                if (target_step > STEP_CB)
                begin
                    // only set step can name a bad step; the step is kept
                    armed_next = 1'b0;
                    duty_next  = '0;
                    gate_next  = '0;
                    fault      = 1'b1;
                end
                else
                begin
                    step_next = target_step;
                    if (mode_bad)
                    begin
                        armed_next = 1'b0;
                        duty_next  = '0;
                        gate_next  = '0;
                        fault      = 1'b1;
                    end
                    else
                    begin
                        gate_next = mapped_gates;
                    end
                end
            end
            CMD_SET_DUTY:
            begin
                if (ctl.item.duty_fraction > DUTY_ONE)
                begin
                    armed_next = 1'b0;
                    duty_next  = '0;
                    gate_next  = '0;
                    fault      = 1'b1;
                end
                else
                begin
                    duty_next = duty_sat;
                end
            end
            default:
            begin
                fault = 1'b0;
            end
        endcase
    end

    // state update, one item per fire
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_AB;
            armed_reg <= 1'b0;
            duty_reg  <= '0;
            gate_reg  <= '0;
        end
        else if (ctl.fire)
        begin
            step_reg  <= step_next;
            armed_reg <= armed_next;
            duty_reg  <= duty_next;
            gate_reg  <= gate_next;
        end
    end

    assign result.gates = gate_next;
    assign result.step  = step_next;
    assign result.armed = armed_next;
    assign result.fault = fault;

    // checks
    `SSC_ASSERT_NOW(a_disarmed_gates_zero, clk, rst_n, !armed_reg, gate_reg == '0)
    `SSC_ASSERT_NOW(a_step_in_range, clk, rst_n, 1'b1, step_reg <= STEP_CB)
    `SSC_ASSERT_NEXT(a_fault_disarms, clk, rst_n, ctl.fire && fault, !armed_reg && duty_reg == '0)

endmodule

[hdl/six_step_commutation_gate_driver_top.sv]
// ----------------------------------------------------------------------------
// six_step_commutation_gate_driver_top
// six-step BLDC commutation driver: command items in, gate compare items out
// ----------------------------------------------------------------------------
// One item per clock cycle, sustained while res.ready is held high. Each
// accepted command item goes into an input register, is evaluated against the
// driver state (step table lookup, mode role mapping and one 16x16 duty
// multiply) and its result goes into the output register, from which it is
// presented. A result waiting on the output side holds the output register
// while the input register still takes one more item; the input side stalls
// only when both are full. Every command gives exactly one result.
// Configuration registers (0 pwm_period, 1 commutation_mode) are written
// through cfg_we/cfg_index/cfg_data; the user must do so only while no item
// is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "six_step_commutation_gate_driver_top_macros.svh"

module six_step_commutation_gate_driver_top
    import ssc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    ssc_cmd_if.sink                   cmd,
    ssc_res_if.source                 res
);

    logic s1_valid_reg;
    cmd_t s1_item_reg;
    logic out_valid_reg;
    res_t out_reg;
    logic advance;
    ctl_t ctl;
    res_t result;

    // the output register can take a new item when empty or being read
    assign advance   = !out_valid_reg || res.ready;
    assign cmd.ready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_item_reg.command       <= cmd.command;
            s1_item_reg.step_value    <= cmd.step_value;
            s1_item_reg.duty_fraction <= cmd.duty_fraction;
        end
    end

    // evaluate the held item
    assign ctl.fire = s1_valid_reg && advance;
    assign ctl.item = s1_item_reg;

    ssc_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .result    (result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            out_reg <= result;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.compare_a_low  = out_reg.gates[GATE_A_LOW];
    assign res.compare_a_high = out_reg.gates[GATE_A_HIGH];
    assign res.compare_b_low  = out_reg.gates[GATE_B_LOW];
    assign res.compare_b_high = out_reg.gates[GATE_B_HIGH];
    assign res.compare_c_low  = out_reg.gates[GATE_C_LOW];
    assign res.compare_c_high = out_reg.gates[GATE_C_HIGH];
    assign res.current_step   = out_reg.step;
    assign res.is_armed       = out_reg.armed;
    assign res.fault          = out_reg.fault;

    // checks
    `SSC_ASSERT_NEXT(a_fire_fills_output, clk, rst_n, ctl.fire, out_valid_reg)
    `SSC_ASSERT_NEXT(a_stalled_item_held, clk, rst_n, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_item_reg))

endmodule
